// ===== rtl/fcp_pkg.sv =====
// Shared types, constants and CRC function for the framed command parser.
package fcp_pkg;

   localparam logic [7:0] HEAD_FIRST  = 8'h55;
   localparam logic [7:0] HEAD_SECOND = 8'hAA;
   localparam logic [7:0] CRC_POLY    = 8'h07;
   localparam logic [7:0] CRC_INIT    = 8'h00;
   localparam logic [7:0] MODE_MIN    = 8'h01;
   localparam logic [7:0] MODE_MAX    = 8'h0F;

   // configuration register indexes
   localparam logic [1:0] CSR_SET_MODE_CMD    = 2'd0;
   localparam logic [1:0] CSR_GET_MODE_CMD    = 2'd1;
   localparam logic [1:0] CSR_REPORT_MODE_CMD = 2'd2;

   localparam logic [7:0] SET_MODE_CMD_RESET    = 8'd1;
   localparam logic [7:0] GET_MODE_CMD_RESET    = 8'd2;
   localparam logic [7:0] REPORT_MODE_CMD_RESET = 8'd3;

   // reply byte positions
   localparam logic [2:0] REPLY_HEAD1 = 3'd0;
   localparam logic [2:0] REPLY_HEAD2 = 3'd1;
   localparam logic [2:0] REPLY_CMD   = 3'd2;
   localparam logic [2:0] REPLY_MODE  = 3'd3;
   localparam logic [2:0] REPLY_CRC   = 3'd4;

   typedef enum logic [2:0] {
      PH_HEAD1 = 3'd0,
      PH_HEAD2 = 3'd1,
      PH_CMD   = 3'd2,
      PH_MODE  = 3'd3,
      PH_CRC   = 3'd4
   } fcp_phase_type;

   // reply descriptor handed from the parser to the serializer
   typedef struct packed {
      logic [7:0] cmd;
      logic [7:0] mode;
      logic       strobe;
   } fcp_reply_type;

   // one byte of CRC-8, MSB first, no reflection
   function automatic logic [7:0] fcp_crc8(input logic [7:0] crc, input logic [7:0] data);
      logic [7:0] c;
      c = crc ^ data;
      for (int k = 0; k < 8; k++) begin
         if (c[7]) begin
            c = {c[6:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[6:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

// ===== rtl/fcp_req_if.sv =====
// Received byte channel.
interface fcp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

// ===== rtl/fcp_rsp_if.sv =====
// Reply byte channel.
interface fcp_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] tx_byte;
   logic       last_byte;
   logic       mode_set_strobe;
   logic [3:0] new_mode;

   modport source (output valid, output tx_byte, output last_byte,
                   output mode_set_strobe, output new_mode, input ready);
   modport sink   (input valid, input tx_byte, input last_byte,
                   input mode_set_strobe, input new_mode, output ready);
endinterface

// ===== rtl/framed_command_parser_crc8_core.sv =====
// Framed command parser with CRC-8 check and five-byte reply generation.
//
// Received bytes arrive one per transfer on req. The parser hunts for the
// header 0x55 0xAA (a repeated 0x55 keeps it waiting for 0xAA), captures a
// command byte and a mode byte, then compares the fifth byte against a CRC-8
// (poly 0x07, init 0, MSB first) over command and mode. A good set-mode frame
// with mode 1..15 yields an echo reply whose first byte carries
// mode_set_strobe and new_mode; a good get-mode frame yields a report reply
// with the report command code and the received mode. A reply is five
// transfers on rsp: 0x55, 0xAA, command, mode, CRC, with last_byte on the CRC.
// Rate: one received byte per cycle, apart from the stall below. Each byte
// is parsed in the cycle it is taken; a reply leaves the serializer register
// one byte per cycle while rsp is ready, starting the cycle after the CRC
// byte. The single reply buffer is the only stall: a CRC byte waits while a
// previous reply still has bytes to send, which can only happen when rsp is
// back-pressured, since frames are five bytes long. Command codes sit in
// three CSRs written through csr_we/csr_index/csr_wdata; index 3 is ignored.
module framed_command_parser_crc8_core (
   input  logic       clock,
   input  logic       reset,
   fcp_req_if.sink    req,
   fcp_rsp_if.source  rsp,
   input  logic       csr_we,
   input  logic [1:0] csr_index,
   input  logic [7:0] csr_wdata
);
   import fcp_pkg::*;

   // command code registers
   logic [7:0] set_cmd_ff;
   logic [7:0] get_cmd_ff;
   logic [7:0] report_cmd_ff;

   // parser state
   fcp_phase_type phase_ff, phase_in;
   logic [7:0]    cmd_ff, cmd_in;
   logic [7:0]    mode_ff, mode_in;

   logic          accept;
   logic          ser_free;
   logic          reply_load;
   fcp_reply_type reply;
   logic [7:0]    frame_crc;
   logic          crc_ok;
   logic          mode_ok;

   always_ff @(posedge clock) begin
      if (reset) begin
         set_cmd_ff    <= SET_MODE_CMD_RESET;
         get_cmd_ff    <= GET_MODE_CMD_RESET;
         report_cmd_ff <= REPORT_MODE_CMD_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_SET_MODE_CMD:    set_cmd_ff    <= csr_wdata;
            CSR_GET_MODE_CMD:    get_cmd_ff    <= csr_wdata;
            CSR_REPORT_MODE_CMD: report_cmd_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Only the CRC byte can start a reply, so only it waits on the buffer.
   assign req.ready = (phase_ff != PH_CRC) || ser_free;
   assign accept    = req.valid & req.ready;

   assign frame_crc = fcp_crc8(fcp_crc8(CRC_INIT, cmd_ff), mode_ff);
   assign crc_ok    = (frame_crc == req.rx_byte);
   assign mode_ok   = (mode_ff >= MODE_MIN) && (mode_ff <= MODE_MAX);

   always_comb begin
      phase_in   = phase_ff;
      cmd_in     = cmd_ff;
      mode_in    = mode_ff;
      reply_load = 1'b0;
      reply      = '{cmd: set_cmd_ff, mode: mode_ff, strobe: 1'b1};
      if (accept) begin
         unique case (phase_ff)
            PH_HEAD1: begin
               if (req.rx_byte == HEAD_FIRST) begin
                  phase_in = PH_HEAD2;
               end
            end
            PH_HEAD2: begin
               if (req.rx_byte == HEAD_SECOND) begin
                  phase_in = PH_CMD;
               end else if (req.rx_byte != HEAD_FIRST) begin
                  phase_in = PH_HEAD1;
               end
            end
            PH_CMD: begin
               cmd_in   = req.rx_byte;
               phase_in = PH_MODE;
            end
            PH_MODE: begin
               mode_in  = req.rx_byte;
               phase_in = PH_CRC;
            end
            PH_CRC: begin
               phase_in = PH_HEAD1;
               if (crc_ok) begin
                  // set code wins when both codes match
                  if (cmd_ff == set_cmd_ff) begin
                     reply_load = mode_ok;
                  end else if (cmd_ff == get_cmd_ff) begin
                     reply_load = 1'b1;
                     reply      = '{cmd: report_cmd_ff, mode: mode_ff, strobe: 1'b0};
                  end
               end
            end
            default: begin
               phase_in = PH_HEAD1;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HEAD1;
      end else begin
         phase_ff <= phase_in;
      end
      cmd_ff  <= cmd_in;
      mode_ff <= mode_in;
   end

   fcp_reply_ser u_reply_ser (
      .clock     (clock),
      .reset     (reset),
      .load      (reply_load),
      .load_data (reply),
      .free      (ser_free),
      .rsp       (rsp)
   );

endmodule

// ===== rtl/fcp_reply_ser.sv =====
// Reply serializer: holds one reply and sends its five bytes.
module fcp_reply_ser (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load,
   input  fcp_pkg::fcp_reply_type load_data,
   output logic                  free,
   fcp_rsp_if.source             rsp
);
   import fcp_pkg::*;

   logic          busy_ff, busy_in;
   logic [2:0]    idx_ff, idx_in;
   fcp_reply_type data_ff, data_in;
   logic [7:0]    crc_ff, crc_in;
   logic          fire;
   logic          done;

   assign fire = busy_ff & rsp.ready;
   assign done = fire && (idx_ff == REPLY_CRC);
   assign free = !busy_ff || done;

   always_comb begin
      busy_in = busy_ff;
      idx_in  = idx_ff;
      data_in = data_ff;
      crc_in  = crc_ff;
      if (load) begin
         busy_in = 1'b1;
         idx_in  = REPLY_HEAD1;
         data_in = load_data;
         crc_in  = fcp_crc8(fcp_crc8(CRC_INIT, load_data.cmd), load_data.mode);
      end else if (fire) begin
         if (done) begin
            busy_in = 1'b0;
         end else begin
            idx_in = idx_ff + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= REPLY_HEAD1;
      end else begin
         busy_ff <= busy_in;
         idx_ff  <= idx_in;
      end
      data_ff <= data_in;
      crc_ff  <= crc_in;
   end

   always_comb begin
      case (idx_ff)
         REPLY_HEAD1: rsp.tx_byte = HEAD_FIRST;
         REPLY_HEAD2: rsp.tx_byte = HEAD_SECOND;
         REPLY_CMD:   rsp.tx_byte = data_ff.cmd;
         REPLY_MODE:  rsp.tx_byte = data_ff.mode;
         default:     rsp.tx_byte = crc_ff;
      endcase
   end

   assign rsp.valid           = busy_ff;
   assign rsp.last_byte       = (idx_ff == REPLY_CRC);
   assign rsp.mode_set_strobe = data_ff.strobe && (idx_ff == REPLY_HEAD1);
   assign rsp.new_mode        = rsp.mode_set_strobe ? data_ff.mode[3:0] : 4'd0;

endmodule

// ===== rtl/fcp_checker.sv =====
// Port-level checks for the framed command parser, bound to the top level.
module fcp_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_tx_byte,
   input logic       rsp_last_byte,
   input logic       rsp_mode_set_strobe,
   input logic [3:0] rsp_new_mode
);
   import fcp_pkg::*;

   // a stalled reply byte holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_tx_byte))
      else $error("reply byte changed while stalled");

   // strobe only on the first header byte, with a nonzero mode
   a_strobe_head: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_mode_set_strobe |-> rsp_tx_byte == HEAD_FIRST && rsp_new_mode != 4'd0)
      else $error("mode strobe off the first header byte");

   // new_mode is zero away from the strobe
   a_mode_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_mode_set_strobe |-> rsp_new_mode == 4'd0)
      else $error("new_mode nonzero without strobe");

   // a frame ends, then the next transfer starts a new header
   a_last_then_head: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_last_byte |=> !rsp_valid || rsp_tx_byte == HEAD_FIRST)
      else $error("reply did not restart at header after last byte");

endmodule

bind framed_command_parser_crc8_core fcp_checker u_fcp_checker (
   .clock               (clock),
   .reset               (reset),
   .rsp_valid           (rsp.valid),
   .rsp_ready           (rsp.ready),
   .rsp_tx_byte         (rsp.tx_byte),
   .rsp_last_byte       (rsp.last_byte),
   .rsp_mode_set_strobe (rsp.mode_set_strobe),
   .rsp_new_mode        (rsp.new_mode)
);

// ===== verif/framed_command_parser_crc8_core_test.sv =====
// Self-checking testbench for the framed command parser with CRC-8 reply generation.
`timescale 1ns / 1ps

module framed_command_parser_crc8_core_test;
   import fcp_pkg::*;

   // index 3 is outside the register file; writes there must be dropped
   localparam logic [1:0] CSR_UNUSED = 2'd3;

   // one byte of a reply frame as it leaves rsp
   typedef struct packed {
      logic [7:0] tx_byte;
      logic       last_byte;
      logic       mode_set_strobe;
      logic [3:0] new_mode;
   } reply_byte_type;

   // Tracks the parser state and command codes, and holds the reply bytes
   // still owed by the block, oldest first.
   class fcp_scoreboard;
      logic [7:0]     set_cmd;
      logic [7:0]     get_cmd;
      logic [7:0]     report_cmd;
      fcp_phase_type  rx_phase;
      logic [7:0]     held_cmd;
      logic [7:0]     held_mode;
      reply_byte_type replies_owed[$];
      bit             failed;

      function new();
         set_cmd    = SET_MODE_CMD_RESET;
         get_cmd    = GET_MODE_CMD_RESET;
         report_cmd = REPORT_MODE_CMD_RESET;
         rx_phase   = PH_HEAD1;
         held_cmd   = 8'h00;
         held_mode  = 8'h00;
         failed     = 1'b0;
      endfunction

      function void write_reg(logic [1:0] idx, logic [7:0] value);
         case (idx)
            CSR_SET_MODE_CMD:    set_cmd = value;
            CSR_GET_MODE_CMD:    get_cmd = value;
            CSR_REPORT_MODE_CMD: report_cmd = value;
            default: ;
         endcase
      endfunction

      // bit-serial CRC-8, poly 0x07, init 0, over command then mode
      function logic [7:0] frame_crc(logic [7:0] cmd, logic [7:0] mode);
         logic [15:0] msg;
         logic [7:0]  r;
         logic        fb;
         msg = {cmd, mode};
         r = CRC_INIT;
         for (int i = 15; i >= 0; i--) begin
            fb = r[7] ^ msg[i];
            r = {r[6:0], 1'b0};
            if (fb) begin
               r = r ^ CRC_POLY;
            end
         end
         return r;
      endfunction

      function void owe_reply(logic [7:0] cmd, logic [7:0] mode, logic strobe);
         replies_owed.push_back('{HEAD_FIRST, 1'b0, strobe, strobe ? mode[3:0] : 4'h0});
         replies_owed.push_back('{HEAD_SECOND, 1'b0, 1'b0, 4'h0});
         replies_owed.push_back('{cmd, 1'b0, 1'b0, 4'h0});
         replies_owed.push_back('{mode, 1'b0, 1'b0, 4'h0});
         replies_owed.push_back('{frame_crc(cmd, mode), 1'b1, 1'b0, 4'h0});
      endfunction

      // advance the parser by one received byte
      function void note_byte(logic [7:0] b);
         case (rx_phase)
            PH_HEAD1: begin
               if (b == HEAD_FIRST) begin
                  rx_phase = PH_HEAD2;
               end
            end
            PH_HEAD2: begin
               if (b == HEAD_SECOND) begin
                  rx_phase = PH_CMD;
               end else if (b != HEAD_FIRST) begin
                  rx_phase = PH_HEAD1;
               end
            end
            PH_CMD: begin
               held_cmd = b;
               rx_phase = PH_MODE;
            end
            PH_MODE: begin
               held_mode = b;
               rx_phase = PH_CRC;
            end
            PH_CRC: begin
               if (frame_crc(held_cmd, held_mode) == b) begin
                  // set-mode wins when both codes match
                  if (held_cmd == set_cmd) begin
                     if (held_mode >= MODE_MIN && held_mode <= MODE_MAX) begin
                        owe_reply(set_cmd, held_mode, 1'b1);
                     end
                  end else if (held_cmd == get_cmd) begin
                     owe_reply(report_cmd, held_mode, 1'b0);
                  end
               end
               rx_phase = PH_HEAD1;
            end
            default: rx_phase = PH_HEAD1;
         endcase
      endfunction

      function void check_reply(reply_byte_type got);
         reply_byte_type want;
         if (replies_owed.size() == 0) begin
            $error("unexpected reply byte %0h", got.tx_byte);
            failed = 1'b1;
            return;
         end
         want = replies_owed.pop_front();
         if (got.tx_byte !== want.tx_byte) begin
            $error("tx_byte: expected %0h, got %0h", want.tx_byte, got.tx_byte);
            failed = 1'b1;
         end
         if (got.last_byte !== want.last_byte) begin
            $error("last_byte: expected %0h, got %0h", want.last_byte, got.last_byte);
            failed = 1'b1;
         end
         if (got.mode_set_strobe !== want.mode_set_strobe) begin
            $error("mode_set_strobe: expected %0h, got %0h",
                   want.mode_set_strobe, got.mode_set_strobe);
            failed = 1'b1;
         end
         if (got.new_mode !== want.new_mode) begin
            $error("new_mode: expected %0h, got %0h", want.new_mode, got.new_mode);
            failed = 1'b1;
         end
      endfunction

      function int pending();
         return replies_owed.size();
      endfunction
   endclass

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       csr_we;
   logic [1:0] csr_index;
   logic [7:0] csr_wdata;

   fcp_req_if req_ch ();
   fcp_rsp_if rsp_ch ();

   // idle odds in percent, changed per phase by the main sequence
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;

   fcp_scoreboard sb = new();

   framed_command_parser_crc8_core DUT (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .rsp       (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   // Reply side: check every transfer, then pick ready for the next cycle.
   // Values are sampled before this edge's updates land, so ready here is
   // the one driven at the previous edge.
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         sb.check_reply('{rsp_ch.tx_byte, rsp_ch.last_byte,
                          rsp_ch.mode_set_strobe, rsp_ch.new_mode});
      end
      rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // Push one byte through req. Leaves valid high on return so that
   // back-to-back bytes keep valid high; the caller lowers it when done.
   task automatic send_byte(input logic [7:0] b);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.rx_byte <= b;
      do @(posedge clock); while (!req_ch.ready);
      sb.note_byte(b);
   endtask

   // header, command, mode and the given check byte
   task automatic send_frame(input logic [7:0] cmd, input logic [7:0] mode,
                             input logic [7:0] check);
      send_byte(HEAD_FIRST);
      send_byte(HEAD_SECOND);
      send_byte(cmd);
      send_byte(mode);
      send_byte(check);
   endtask

   task automatic send_good_frame(input logic [7:0] cmd, input logic [7:0] mode);
      send_frame(cmd, mode, sb.frame_crc(cmd, mode));
   endtask

   // Stop sending, wait for every owed reply byte, then let the block settle
   // (a dropped frame produces nothing to wait for).
   task automatic wait_replies_done();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // one register write, only ever issued while the block is idle
   task automatic write_csr(input logic [1:0] idx, input logic [7:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      sb.write_reg(idx, value);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // Mostly well-formed frames with random content; the rest are bad CRCs,
   // repeated header bytes, broken headers and plain noise.
   task automatic send_mixed_traffic(input int byte_budget);
      int         sent;
      int         kind;
      int         pick;
      int         reps;
      logic [7:0] cmd;
      logic [7:0] mode;
      sent = 0;
      while (sent < byte_budget) begin
         pick = $urandom_range(99);
         if (pick < 40) begin
            cmd = sb.set_cmd;
         end else if (pick < 75) begin
            cmd = sb.get_cmd;
         end else if (pick < 85) begin
            cmd = sb.report_cmd;
         end else begin
            cmd = 8'($urandom_range(255));
         end
         pick = $urandom_range(99);
         if (pick < 60) begin
            mode = 8'($urandom_range(MODE_MAX, MODE_MIN));
         end else if (pick < 70) begin
            mode = 8'h00;
         end else if (pick < 80) begin
            mode = MODE_MAX + 8'd1;
         end else begin
            mode = 8'($urandom_range(255));
         end
         kind = $urandom_range(99);
         if (kind < 65) begin
            send_good_frame(cmd, mode);
            sent += 5;
         end else if (kind < 77) begin
            // single flipped bit in the check byte
            send_frame(cmd, mode, sb.frame_crc(cmd, mode) ^ (8'h01 << $urandom_range(7)));
            sent += 5;
         end else if (kind < 87) begin
            reps = $urandom_range(3, 1);
            repeat (reps) send_byte(HEAD_FIRST);
            send_good_frame(cmd, mode);
            sent += reps + 5;
         end else if (kind < 93) begin
            // header start followed by junk
            send_byte(HEAD_FIRST);
            send_byte(8'($urandom_range(255)));
            sent += 2;
         end else begin
            reps = $urandom_range(4, 1);
            repeat (reps) send_byte(8'($urandom_range(255)));
            sent += reps;
         end
      end
   endtask

   initial begin
      logic [7:0] shared_cmd;

      req_ch.valid   = 1'b0;
      req_ch.rx_byte = 8'h00;
      csr_we         = 1'b0;
      csr_index      = CSR_SET_MODE_CMD;
      csr_wdata      = 8'h00;

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed frames with the reset command codes, no idling
      send_good_frame(SET_MODE_CMD_RESET, MODE_MIN);          // echo with strobe
      send_good_frame(GET_MODE_CMD_RESET, 8'hFF);             // report, top mode byte
      send_byte(HEAD_FIRST);                                  // repeated first header byte
      send_good_frame(SET_MODE_CMD_RESET, MODE_MAX);
      send_frame(GET_MODE_CMD_RESET, 8'h00,                   // bad CRC, dropped
                 sb.frame_crc(GET_MODE_CMD_RESET, 8'h00) ^ 8'h80);
      send_byte(HEAD_FIRST);                                  // wrong second header byte
      send_byte(8'h00);
      send_good_frame(SET_MODE_CMD_RESET, 8'h00);             // set-mode, mode zero: silent

      // phase 0: reset codes, no idling on either side
      send_mixed_traffic(85);
      wait_replies_done();

      // phase 1: extreme codes, sender mostly idle
      write_csr(CSR_SET_MODE_CMD, 8'hFF);
      write_csr(CSR_GET_MODE_CMD, 8'h00);
      write_csr(CSR_REPORT_MODE_CMD, 8'h00);
      send_idle_pct  = 77;
      recv_stall_pct = 0;
      send_mixed_traffic(85);
      wait_replies_done();

      // phase 2: set code zero, random get and report codes, receiver mostly
      // stalled; the out-of-range index write must not land
      write_csr(CSR_SET_MODE_CMD, 8'h00);
      write_csr(CSR_GET_MODE_CMD, 8'($urandom_range(255, 1)));
      write_csr(CSR_REPORT_MODE_CMD, 8'($urandom_range(255)));
      write_csr(CSR_UNUSED, 8'h00);
      send_idle_pct  = 0;
      recv_stall_pct = 77;
      send_mixed_traffic(85);
      wait_replies_done();

      // phase 3: first set and get share a code, so set-mode takes the
      // frame and an out-of-range mode gives nothing
      shared_cmd = 8'($urandom_range(255));
      write_csr(CSR_SET_MODE_CMD, shared_cmd);
      write_csr(CSR_GET_MODE_CMD, shared_cmd);
      write_csr(CSR_REPORT_MODE_CMD, 8'hFF);
      send_idle_pct  = 14;
      recv_stall_pct = 14;
      send_good_frame(shared_cmd, 8'h20);
      send_good_frame(shared_cmd, 8'h07);
      wait_replies_done();
      write_csr(CSR_GET_MODE_CMD, ~shared_cmd);
      send_mixed_traffic(85);
      wait_replies_done();

      if (!sb.failed && sb.pending() == 0) begin
         $display("framed_command_parser_crc8_core: match");
      end else begin
         $display("framed_command_parser_crc8_core: mismatch");
      end
      $finish;
   end

   // watchdog: a hung handshake ends the run here
   initial begin
      #2_000_000;
      $display("framed_command_parser_crc8_core: mismatch");
      $finish;
   end

endmodule
